FILE: src/sgi_pkg.sv
// Shared constants for the 2D segment intersection pipeline.
// No dependencies.
package sgi_pkg;

  // Default coordinate width (signed fixed point, binary point is irrelevant to the math)
  localparam int COORD_BITS_DEF = 24;

  // Intersection test modes
  localparam logic MODE_SEGMENT = 1'b0;
  localparam logic MODE_LINE    = 1'b1;

endpackage

FILE: src/sgi_side.sv
// Side-value stages: coordinate differences, cross products, side values.
// Depends on sgi_pkg.
module sgi_side
  import sgi_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic signed [COORD_BITS-1:0]  asx,
  input  logic signed [COORD_BITS-1:0]  asy,
  input  logic signed [COORD_BITS-1:0]  aex,
  input  logic signed [COORD_BITS-1:0]  aey,
  input  logic signed [COORD_BITS-1:0]  bsx,
  input  logic signed [COORD_BITS-1:0]  bsy,
  input  logic signed [COORD_BITS-1:0]  bex,
  input  logic signed [COORD_BITS-1:0]  bey,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          o_mode,
  output logic signed [COORD_BITS-1:0]  o_asx,
  output logic signed [COORD_BITS-1:0]  o_asy,
  output logic signed [COORD_BITS-1:0]  o_aex,
  output logic signed [COORD_BITS-1:0]  o_aey,
  output logic signed [2*COORD_BITS+2:0] sa,
  output logic signed [2*COORD_BITS+2:0] ea,
  output logic signed [2*COORD_BITS+2:0] sb,
  output logic signed [2*COORD_BITS+2:0] eb
);

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic [2:0] v;
  logic [3:0] rdy;

  // stage 1 registers
  logic                 m1;
  logic signed [CW-1:0] asx1, asy1, aex1, aey1;
  logic signed [DW-1:0] dbx, dby, qsx, qsy, qex, qey;
  logic signed [DW-1:0] dax, day, rsx, rsy, rex, rey;
  // stage 2 registers
  logic                 m2;
  logic signed [CW-1:0] asx2, asy2, aex2, aey2;
  logic signed [PW-1:0] pa1, pa2, pe1, pe2, pb1, pb2, pf1, pf2;

  // stall chain: a stage takes new data when empty or when its successor moves
  always_comb begin
    rdy[3] = out_ready;
    for (int k = 2; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end
  assign in_ready  = rdy[0];
  assign out_valid = v[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
    end
  end

  // stage 1: differences against line B and line A
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      m1   <= mode;
      asx1 <= asx;
      asy1 <= asy;
      aex1 <= aex;
      aey1 <= aey;
      dbx  <= DW'(bex) - DW'(bsx);
      dby  <= DW'(bey) - DW'(bsy);
      qsx  <= DW'(asx) - DW'(bsx);
      qsy  <= DW'(asy) - DW'(bsy);
      qex  <= DW'(aex) - DW'(bsx);
      qey  <= DW'(aey) - DW'(bsy);
      dax  <= DW'(aex) - DW'(asx);
      day  <= DW'(aey) - DW'(asy);
      rsx  <= DW'(bsx) - DW'(asx);
      rsy  <= DW'(bsy) - DW'(asy);
      rex  <= DW'(bex) - DW'(asx);
      rey  <= DW'(bey) - DW'(asy);
    end
  end

  // stage 2: cross-product terms
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      m2   <= m1;
      asx2 <= asx1;
      asy2 <= asy1;
      aex2 <= aex1;
      aey2 <= aey1;
      pa1  <= dbx * qsy;
      pa2  <= dby * qsx;
      pe1  <= dbx * qey;
      pe2  <= dby * qex;
      pb1  <= dax * rsy;
      pb2  <= day * rsx;
      pf1  <= dax * rey;
      pf2  <= day * rex;
    end
  end

  // stage 3: side values
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      o_mode <= m2;
      o_asx  <= asx2;
      o_asy  <= asy2;
      o_aex  <= aex2;
      o_aey  <= aey2;
      sa     <= SW'(pa1) - SW'(pa2);
      ea     <= SW'(pe1) - SW'(pe2);
      sb     <= SW'(pb1) - SW'(pb2);
      eb     <= SW'(pf1) - SW'(pf2);
    end
  end

endmodule

FILE: src/sgi_numer.sv
// Hit decision, denominator magnitude and interpolation numerator (two stages).
// Depends on sgi_pkg.
module sgi_numer
  import sgi_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           mode,
  input  logic signed [COORD_BITS-1:0]   asx,
  input  logic signed [COORD_BITS-1:0]   asy,
  input  logic signed [COORD_BITS-1:0]   aex,
  input  logic signed [COORD_BITS-1:0]   aey,
  input  logic signed [2*COORD_BITS+2:0] sa,
  input  logic signed [2*COORD_BITS+2:0] ea,
  input  logic signed [2*COORD_BITS+2:0] sb,
  input  logic signed [2*COORD_BITS+2:0] eb,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           o_hit,
  output logic                           o_negx,
  output logic                           o_negy,
  output logic [3*COORD_BITS+1:0]        o_nx,
  output logic [3*COORD_BITS+1:0]        o_ny,
  output logic [2*COORD_BITS+2:0]        o_dd,
  output logic signed [COORD_BITS-1:0]   o_asx,
  output logic signed [COORD_BITS-1:0]   o_asy
);

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int SW = 2 * CW + 3;
  localparam int MA = SW - 1;
  localparam int NW = 3 * CW + 2;
  localparam int FW = 3 * DW;

  logic [1:0] v;
  logic [2:0] rdy;

  logic               sa_neg, ea_neg, sb_neg, eb_neg, hit_c;
  logic [SW-1:0]      sa_mag;
  logic signed [SW:0] den;
  logic [SW:0]        den_mag;
  logic signed [DW-1:0] dirx, diry;
  logic [DW-1:0]      dirx_mag, diry_mag;

  // stage 4 registers
  logic                 hit4, negx4, negy4;
  logic [2*DW-1:0]      plox, phix, ploy, phiy;
  logic [SW-1:0]        dd4;
  logic signed [CW-1:0] asx4, asy4;

  assign rdy[2] = out_ready;
  assign rdy[1] = !v[1] || rdy[2];
  assign rdy[0] = !v[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = v[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
    end
  end

  // strict straddle tests and magnitudes
  always_comb begin
    sa_neg = sa[SW-1];
    ea_neg = ea[SW-1];
    sb_neg = sb[SW-1];
    eb_neg = eb[SW-1];
    hit_c  = (sa != '0) && (ea != '0) && (sa_neg != ea_neg) &&
             ((mode == MODE_LINE) || ((sb != '0) && (eb != '0) && (sb_neg != eb_neg)));
    sa_mag = sa_neg ? SW'(-sa) : SW'(sa);
    den    = (SW+1)'(sa) - (SW+1)'(ea);
    den_mag = den[SW] ? (SW+1)'(-den) : (SW+1)'(den);
    dirx   = DW'(aex) - DW'(asx);
    diry   = DW'(aey) - DW'(asy);
    dirx_mag = dirx[DW-1] ? DW'(-dirx) : DW'(dirx);
    diry_mag = diry[DW-1] ? DW'(-diry) : DW'(diry);
  end

  // stage 4: partial products of |dir| * |sA|, split in two halves
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      hit4  <= hit_c;
      negx4 <= dirx[DW-1] ^ sa_neg ^ den[SW];
      negy4 <= diry[DW-1] ^ sa_neg ^ den[SW];
      plox  <= dirx_mag * sa_mag[DW-1:0];
      phix  <= dirx_mag * sa_mag[MA-1:DW];
      ploy  <= diry_mag * sa_mag[DW-1:0];
      phiy  <= diry_mag * sa_mag[MA-1:DW];
      dd4   <= den_mag[SW-1:0];
      asx4  <= asx;
      asy4  <= asy;
    end
  end

  // stage 5: combine partial products into the full numerator
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      o_hit  <= hit4;
      o_negx <= negx4;
      o_negy <= negy4;
      o_nx   <= NW'(({phix, {DW{1'b0}}}) + FW'(plox));
      o_ny   <= NW'(({phiy, {DW{1'b0}}}) + FW'(ploy));
      o_dd   <= dd4;
      o_asx  <= asx4;
      o_asy  <= asy4;
    end
  end

endmodule

FILE: src/sgi_div.sv
// Pipelined restoring divider, one quotient bit per stage, x and y in parallel.
// Depends on sgi_pkg.
module sgi_div
  import sgi_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         hit,
  input  logic                         negx,
  input  logic                         negy,
  input  logic [3*COORD_BITS+1:0]      nx,
  input  logic [3*COORD_BITS+1:0]      ny,
  input  logic [2*COORD_BITS+2:0]      dd,
  input  logic signed [COORD_BITS-1:0] asx,
  input  logic signed [COORD_BITS-1:0] asy,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         o_hit,
  output logic                         o_negx,
  output logic                         o_negy,
  output logic [COORD_BITS:0]          o_qx,
  output logic [COORD_BITS:0]          o_qy,
  output logic                         o_rx_nz,
  output logic                         o_ry_nz,
  output logic signed [COORD_BITS-1:0] o_asx,
  output logic signed [COORD_BITS-1:0] o_asy
);

  localparam int CW = COORD_BITS;
  localparam int QW = CW + 1;
  localparam int DW = 2 * CW + 3;
  localparam int NW = 3 * CW + 2;

  logic [QW-1:0] v;
  logic [QW:0]   rdy;

  logic                 hit_r  [QW];
  logic                 negx_r [QW];
  logic                 negy_r [QW];
  logic [DW-1:0]        rx     [QW];
  logic [DW-1:0]        ry     [QW];
  logic [QW-1:0]        lx     [QW];
  logic [QW-1:0]        ly     [QW];
  logic [QW-1:0]        qx     [QW];
  logic [QW-1:0]        qy     [QW];
  logic [DW-1:0]        dd_r   [QW];
  logic signed [CW-1:0] asx_r  [QW];
  logic signed [CW-1:0] asy_r  [QW];

  always_comb begin
    rdy[QW] = out_ready;
    for (int k = QW - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end
  assign in_ready  = rdy[0];
  assign out_valid = v[QW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < QW; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < QW; g++) begin : g_step
      logic                 hit_i, negx_i, negy_i;
      logic [DW-1:0]        rx_i, ry_i, dd_i;
      logic [QW-1:0]        lx_i, ly_i, qx_i, qy_i;
      logic signed [CW-1:0] asx_i, asy_i;
      logic [DW:0]          tx, ty;
      logic                 gex, gey;

      // stage inputs: the numerator high part seeds the remainder
      if (g == 0) begin : g_first
        assign hit_i  = hit;
        assign negx_i = negx;
        assign negy_i = negy;
        assign rx_i   = DW'(nx[NW-1:QW]);
        assign ry_i   = DW'(ny[NW-1:QW]);
        assign lx_i   = nx[QW-1:0];
        assign ly_i   = ny[QW-1:0];
        assign qx_i   = '0;
        assign qy_i   = '0;
        assign dd_i   = dd;
        assign asx_i  = asx;
        assign asy_i  = asy;
      end else begin : g_next
        assign hit_i  = hit_r[g-1];
        assign negx_i = negx_r[g-1];
        assign negy_i = negy_r[g-1];
        assign rx_i   = rx[g-1];
        assign ry_i   = ry[g-1];
        assign lx_i   = lx[g-1];
        assign ly_i   = ly[g-1];
        assign qx_i   = qx[g-1];
        assign qy_i   = qy[g-1];
        assign dd_i   = dd_r[g-1];
        assign asx_i  = asx_r[g-1];
        assign asy_i  = asy_r[g-1];
      end

      // shift in next numerator bit, trial subtract
      always_comb begin
        tx  = {rx_i, lx_i[QW-1]};
        ty  = {ry_i, ly_i[QW-1]};
        gex = tx >= {1'b0, dd_i};
        gey = ty >= {1'b0, dd_i};
      end

      always_ff @(posedge clk) begin
        if (rdy[g]) begin
          hit_r[g]  <= hit_i;
          negx_r[g] <= negx_i;
          negy_r[g] <= negy_i;
          rx[g]     <= gex ? DW'(tx - {1'b0, dd_i}) : DW'(tx);
          ry[g]     <= gey ? DW'(ty - {1'b0, dd_i}) : DW'(ty);
          lx[g]     <= {lx_i[QW-2:0], 1'b0};
          ly[g]     <= {ly_i[QW-2:0], 1'b0};
          qx[g]     <= {qx_i[QW-2:0], gex};
          qy[g]     <= {qy_i[QW-2:0], gey};
          dd_r[g]   <= dd_i;
          asx_r[g]  <= asx_i;
          asy_r[g]  <= asy_i;
        end
      end
    end
  endgenerate

  assign o_hit   = hit_r[QW-1];
  assign o_negx  = negx_r[QW-1];
  assign o_negy  = negy_r[QW-1];
  assign o_qx    = qx[QW-1];
  assign o_qy    = qy[QW-1];
  assign o_rx_nz = rx[QW-1] != '0;
  assign o_ry_nz = ry[QW-1] != '0;
  assign o_asx   = asx_r[QW-1];
  assign o_asy   = asy_r[QW-1];

endmodule

FILE: src/segment_intersection_2d_top.sv
// Top level of the 2D segment intersection pipeline and its output register.
// Depends on sgi_pkg, sgi_side, sgi_numer, sgi_div.
//
// Takes one request per cycle unless the output stalls; each request gives exactly one
// result. The path has three stages for side values, two for the numerator,
// COORD_BITS + 1 divider stages (one quotient bit each) and the output register,
// which applies floor rounding and adds the start point. A stall on the output holds
// every stage; empty stages still fill, so no request is lost.
module segment_intersection_2d_top
  import sgi_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [8*COORD_BITS-1:0]               s_tdata,
  // mode
  input  logic                                  s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // cross_x, cross_y, zero pad
  output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
  // hit
  output logic                                  m_tuser
);

  localparam int CW  = COORD_BITS;
  localparam int SW  = 2 * CW + 3;
  localparam int NW  = 3 * CW + 2;
  localparam int QW  = CW + 1;
  localparam int ODW = ((2 * CW + 7) / 8) * 8;

  // side unit -> numerator
  logic                 sv, sr, smode;
  logic signed [CW-1:0] sasx, sasy, saex, saey;
  logic signed [SW-1:0] sa, ea, sb, eb;
  // numerator -> divider
  logic                 nv, nr, nhit, nnegx, nnegy;
  logic [NW-1:0]        nx, ny;
  logic [SW-1:0]        ndd;
  logic signed [CW-1:0] nasx, nasy;
  // divider -> output
  logic                 dv, dr, dhit, dnegx, dnegy, drx_nz, dry_nz;
  logic [QW-1:0]        dqx, dqy;
  logic signed [CW-1:0] dasx, dasy;

  logic [QW:0]          fqx, fqy;
  logic [CW-1:0]        px, py;
  logic                 ov, ohit;
  logic [CW-1:0]        ox, oy;

  sgi_side #(.COORD_BITS(COORD_BITS)) u_side (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .mode      (s_tuser),
    .asx       (s_tdata[0*CW +: CW]),
    .asy       (s_tdata[1*CW +: CW]),
    .aex       (s_tdata[2*CW +: CW]),
    .aey       (s_tdata[3*CW +: CW]),
    .bsx       (s_tdata[4*CW +: CW]),
    .bsy       (s_tdata[5*CW +: CW]),
    .bex       (s_tdata[6*CW +: CW]),
    .bey       (s_tdata[7*CW +: CW]),
    .out_valid (sv),
    .out_ready (sr),
    .o_mode    (smode),
    .o_asx     (sasx),
    .o_asy     (sasy),
    .o_aex     (saex),
    .o_aey     (saey),
    .sa        (sa),
    .ea        (ea),
    .sb        (sb),
    .eb        (eb)
  );

  sgi_numer #(.COORD_BITS(COORD_BITS)) u_numer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sv),
    .in_ready  (sr),
    .mode      (smode),
    .asx       (sasx),
    .asy       (sasy),
    .aex       (saex),
    .aey       (saey),
    .sa        (sa),
    .ea        (ea),
    .sb        (sb),
    .eb        (eb),
    .out_valid (nv),
    .out_ready (nr),
    .o_hit     (nhit),
    .o_negx    (nnegx),
    .o_negy    (nnegy),
    .o_nx      (nx),
    .o_ny      (ny),
    .o_dd      (ndd),
    .o_asx     (nasx),
    .o_asy     (nasy)
  );

  sgi_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nv),
    .in_ready  (nr),
    .hit       (nhit),
    .negx      (nnegx),
    .negy      (nnegy),
    .nx        (nx),
    .ny        (ny),
    .dd        (ndd),
    .asx       (nasx),
    .asy       (nasy),
    .out_valid (dv),
    .out_ready (dr),
    .o_hit     (dhit),
    .o_negx    (dnegx),
    .o_negy    (dnegy),
    .o_qx      (dqx),
    .o_qy      (dqy),
    .o_rx_nz   (drx_nz),
    .o_ry_nz   (dry_nz),
    .o_asx     (dasx),
    .o_asy     (dasy)
  );

  // signed floor quotient and final point
  always_comb begin
    fqx = dnegx ? (QW+1)'(-{1'b0, dqx} - (QW+1)'(drx_nz)) : {1'b0, dqx};
    fqy = dnegy ? (QW+1)'(-{1'b0, dqy} - (QW+1)'(dry_nz)) : {1'b0, dqy};
    px  = CW'(dasx) + fqx[CW-1:0];
    py  = CW'(dasy) + fqy[CW-1:0];
  end

  // output register
  assign dr = !ov || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (dr) begin
      ov <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (dr) begin
      ohit <= dhit;
      ox   <= dhit ? px : '0;
      oy   <= dhit ? py : '0;
    end
  end

  assign m_tvalid = ov;
  assign m_tuser  = ohit;
  assign m_tdata  = ODW'({oy, ox});

endmodule

FILE: verif/segment_intersection_2d_top_tb.sv
// Testbench for segment_intersection_2d_top: drives segment pairs, predicts crossings.
// Depends on sgi_pkg and the segment_intersection_2d_top RTL.
`timescale 1ns / 100ps

class crossing_scoreboard;
  typedef struct {
    logic        hit;
    logic [23:0] cx;
    logic [23:0] cy;
  } crossing_t;

  crossing_t pending[$];
  int        errors;

  // Side of point p against the line s->e, exact in 64 bits
  static function logic signed [63:0] side_of(logic signed [23:0] px, logic signed [23:0] py,
                                             logic signed [23:0] sx, logic signed [23:0] sy,
                                             logic signed [23:0] ex, logic signed [23:0] ey);
    logic signed [63:0] dx, dy, qx, qy;
    dx = 64'(ex) - 64'(sx);
    dy = 64'(ey) - 64'(sy);
    qx = 64'(px) - 64'(sx);
    qy = 64'(py) - 64'(sy);
    return dx * qy - dy * qx;
  endfunction

  static function logic straddle(logic signed [63:0] a, logic signed [63:0] b);
    return a != 0 && b != 0 && (a[63] != b[63]);
  endfunction

  // start + floor((end-start)*num/den)
  static function logic [23:0] lerp_floor(logic signed [23:0] s0, logic signed [23:0] e0,
                                          logic signed [63:0] num, logic signed [63:0] den);
    logic signed [127:0] n, d, q, r;
    n = 128'(64'(e0) - 64'(s0)) * 128'(num);
    d = 128'(den);
    q = n / d;
    r = n % d;
    if (r != 0 && ((r < 0) != (d < 0))) q = q - 1;
    return 24'(128'(s0) + q);
  endfunction

  function void note_request(logic mode, logic [191:0] d);
    logic signed [23:0] c[8];
    logic signed [63:0] sa, ea, sb, eb;
    crossing_t x;
    for (int i = 0; i < 8; i++) c[i] = d[24*i +: 24];
    sa = side_of(c[0], c[1], c[4], c[5], c[6], c[7]);
    ea = side_of(c[2], c[3], c[4], c[5], c[6], c[7]);
    x.hit = straddle(sa, ea);
    if (x.hit && mode == sgi_pkg::MODE_SEGMENT) begin
      sb = side_of(c[4], c[5], c[0], c[1], c[2], c[3]);
      eb = side_of(c[6], c[7], c[0], c[1], c[2], c[3]);
      x.hit = straddle(sb, eb);
    end
    x.cx = x.hit ? lerp_floor(c[0], c[2], sa, sa - ea) : '0;
    x.cy = x.hit ? lerp_floor(c[1], c[3], sa, sa - ea) : '0;
    pending.push_back(x);
  endfunction

  function void check_result(logic hit, logic [47:0] d);
    crossing_t x;
    if (pending.size() == 0) begin
      $error("result with no request pending");
      errors++;
      return;
    end
    x = pending.pop_front();
    if (hit !== x.hit) begin
      $error("hit: expected %0d actual %0d", x.hit, hit); errors++;
    end
    if (d[23:0] !== x.cx) begin
      $error("cross_x: expected %h actual %h", x.cx, d[23:0]); errors++;
    end
    if (d[47:24] !== x.cy) begin
      $error("cross_y: expected %h actual %h", x.cy, d[47:24]); errors++;
    end
  endfunction
endclass

module segment_intersection_2d_top_tb;
  import sgi_pkg::*;

  localparam int IDLE_LIMIT = 5000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic         s_tuser = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [47:0]  m_tdata;
  logic         m_tuser;

  int  src_idle_pct = 0;
  int  sink_stall_pct = 0;
  bit  sink_hold = 0;
  int  idle_cycles = 0;
  crossing_scoreboard board = new();

  segment_intersection_2d_top uut (.*);

  initial forever #2 clk = ~clk;

  // Receiver: random stalls, or held off entirely
  always @(posedge clk) begin
    if (rst || sink_hold) m_tready <= 0;
    else m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Check accepted results; watchdog on accepted traffic
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tuser, m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || sink_hold) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(5))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'(int'($urandom_range(64)) - 32);
      default: return 24'($urandom);
    endcase
  endfunction

  // One request, with random idle before it
  task automatic send_request(logic mode, logic [191:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= d;
    s_tuser  <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request(mode, d);
  endtask

  function automatic logic [191:0] pack8(int c0, int c1, int c2, int c3,
                                         int c4, int c5, int c6, int c7);
    return {24'(c7), 24'(c6), 24'(c5), 24'(c4), 24'(c3), 24'(c2), 24'(c1), 24'(c0)};
  endfunction

  // Random request; mostly built crossings around a shared point
  task automatic send_random();
    logic [191:0] d;
    int px, py, ax, ay, bx, by;
    if ($urandom_range(2) == 0) begin
      for (int i = 0; i < 8; i++) d[24*i +: 24] = rand_coord();
    end else begin
      px = $urandom_range(4000000) - 2000000;
      py = $urandom_range(4000000) - 2000000;
      ax = $urandom_range(2000000) - 1000000;
      ay = $urandom_range(2000000) - 1000000;
      bx = $urandom_range(2000000) - 1000000;
      by = $urandom_range(2000000) - 1000000;
      d = pack8(px - ax, py - ay, px + ax / int'($urandom_range(4) + 1),
                py + ay / int'($urandom_range(4) + 1),
                px - bx, py - by, px + bx, py + by);
    end
    send_request($urandom_range(1), d);
  endtask

  task automatic run_phase(int n, int idle_pct, int stall_pct);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (n) send_random();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: crossing, touch, collinear, degenerate, extremes, both modes
    send_request(MODE_SEGMENT, pack8(-100, -100, 100, 100, -100, 100, 100, -100));
    send_request(MODE_LINE,    pack8(-100, -100, 100, 100, -100, 100, 100, -100));
    send_request(MODE_SEGMENT, pack8(-7, 0, 7, 3, 5, -9, 1, 11));
    send_request(MODE_SEGMENT, pack8(0, 0, 10, 0, 10, -5, 10, 5));
    send_request(MODE_SEGMENT, pack8(0, 0, 10, 0, 20, 0, 30, 0));
    send_request(MODE_SEGMENT, pack8(0, 0, 10, 10, 5, 5, 5, 5));
    send_request(MODE_LINE,    pack8(0, 0, 0, 0, 5, -5, 5, 5));
    send_request(MODE_SEGMENT, pack8(0, 0, 10, 0, 1000, -5, 1000, 5));
    send_request(MODE_LINE,    pack8(0, 0, 10, 0, 1000, -5, 1000, 5));
    send_request(MODE_LINE,    pack8(0, 0, 10, 0, 1000, -5, 1000, 5));
    send_request(MODE_SEGMENT, pack8(-8388608, -8388608, 8388607, 8388607,
                                     -8388608, 8388607, 8388607, -8388608));
    send_request(MODE_LINE,    pack8(8388607, -8388608, -8388608, 8388607,
                                     -8388608, -8388608, 8388607, 8388607));
    send_request(MODE_SEGMENT, pack8(-8388608, 0, 8388607, 1, 3, -8388608, 4, 8388607));
    send_request(MODE_SEGMENT, pack8(1, 2, 2, 4, 0, 3, 3, 3));
    send_request(MODE_LINE,    pack8(-3, -1, 3, 2, 0, 0, 1, 1));
    send_request(MODE_SEGMENT, '1);
    send_request(MODE_LINE,    '0);

    run_phase(200, 0, 0);
    run_phase(200, 51, 0);
    run_phase(200, 0, 51);
    run_phase(150, 15, 15);

    // Long receiver hold while requests keep coming
    sink_stall_pct = 0;
    src_idle_pct   = 0;
    fork
      begin
        sink_hold = 1;
        repeat (300) @(posedge clk);
        sink_hold = 0;
      end
      repeat (150) send_random();
    join
    s_tvalid <= 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
